// File: hdl/asc_pkg.sv
package asc_pkg;

   localparam int unsigned ANGLE_WIDTH = 8;
   localparam int unsigned TICK_WIDTH  = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [ANGLE_WIDTH-1:0] MAX_ANGLE = 8'd180;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UP_POSITION   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOWN_POSITION = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_TICKS    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TICKS    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOCKOUT_TICKS = 3'd4;

   localparam logic [7:0]  RESET_UP_POSITION   = 8'd150;
   localparam logic [7:0]  RESET_DOWN_POSITION = 8'd0;
   localparam logic [7:0]  RESET_STEP_TICKS    = 8'd4;
   localparam logic [15:0] RESET_HOLD_TICKS    = 16'd1500;
   localparam logic [7:0]  RESET_LOCKOUT_TICKS = 8'd50;

   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_ARM    = 2'd1;
   localparam logic [1:0] OP_DISARM = 2'd2;
   localparam logic [1:0] OP_STATUS = 2'd3;

   localparam logic [1:0] EVENT_NONE    = 2'd0;
   localparam logic [1:0] EVENT_STARTED = 2'd1;
   localparam logic [1:0] EVENT_DOWN    = 2'd2;
   localparam logic [1:0] EVENT_DONE    = 2'd3;

   localparam logic [1:0] REPLY_NONE     = 2'd0;
   localparam logic [1:0] REPLY_ARMED    = 2'd1;
   localparam logic [1:0] REPLY_DISARMED = 2'd2;
   localparam logic [1:0] REPLY_STATUS   = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_PREP = 3'd1,
      PH_DOWN = 3'd2,
      PH_HOLD = 3'd3,
      PH_UP   = 3'd4,
      PH_LOCK = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0]  up_position;
      logic [7:0]  down_position;
      logic [7:0]  step_ticks;
      logic [15:0] hold_ticks;
      logic [7:0]  lockout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [ANGLE_WIDTH-1:0] servo_angle;
      logic                   cut_busy;
      logic                   is_armed;
      logic [1:0]             cut_event;
      logic [1:0]             reply;
   } rsp_type;

   function automatic logic [ANGLE_WIDTH-1:0] clamp_angle(input logic [ANGLE_WIDTH-1:0] a);
      return (a > MAX_ANGLE) ? MAX_ANGLE : a;
   endfunction

endpackage

// File: hdl/asc_csr.sv
module asc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 write,
   input  logic [asc_pkg::CSR_INDEX_WIDTH-1:0]  index,
   input  logic [asc_pkg::CSR_DATA_WIDTH-1:0]   data,
   output asc_pkg::cfg_type                     cfg
);

   asc_pkg::cfg_type cfg_ff;
   asc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            asc_pkg::CSR_UP_POSITION:   cfg_in.up_position   = data[7:0];
            asc_pkg::CSR_DOWN_POSITION: cfg_in.down_position = data[7:0];
            asc_pkg::CSR_STEP_TICKS:    cfg_in.step_ticks    = data[7:0];
            asc_pkg::CSR_HOLD_TICKS:    cfg_in.hold_ticks    = data[15:0];
            asc_pkg::CSR_LOCKOUT_TICKS: cfg_in.lockout_ticks = data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_position   <= asc_pkg::RESET_UP_POSITION;
         cfg_ff.down_position <= asc_pkg::RESET_DOWN_POSITION;
         cfg_ff.step_ticks    <= asc_pkg::RESET_STEP_TICKS;
         cfg_ff.hold_ticks    <= asc_pkg::RESET_HOLD_TICKS;
         cfg_ff.lockout_ticks <= asc_pkg::RESET_LOCKOUT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/asc_core.sv
module asc_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [1:0]       operation,
   input  logic             button_level,
   input  asc_pkg::cfg_type cfg,
   output asc_pkg::rsp_type result
);

   logic                                armed_ff, armed_in;
   asc_pkg::phase_type                  phase_ff, phase_in;
   logic [asc_pkg::ANGLE_WIDTH-1:0]     angle_ff, angle_in;
   logic [asc_pkg::TICK_WIDTH-1:0]      tick_ff, tick_in;
   logic                                prev_button_ff;

   logic [asc_pkg::ANGLE_WIDTH-1:0] up, down, ramp_target;
   logic [asc_pkg::TICK_WIDTH-1:0]  tick_inc, step_min, hold_min, lock_min;
   logic                            ramp_done;
   logic [1:0]                      event_code, reply_code;

   assign up       = asc_pkg::clamp_angle(cfg.up_position);
   assign down     = asc_pkg::clamp_angle(cfg.down_position);
   assign tick_inc = tick_ff + 16'd1;
   assign step_min = (cfg.step_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.step_ticks};
   assign hold_min = (cfg.hold_ticks == 16'd0) ? 16'd1 : cfg.hold_ticks;
   assign lock_min = (cfg.lockout_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.lockout_ticks};
   assign ramp_target = (phase_ff == asc_pkg::PH_DOWN) ? down : up;

   always_comb begin
      armed_in   = armed_ff;
      reply_code = asc_pkg::REPLY_NONE;
      case (operation)
         asc_pkg::OP_ARM: begin
            armed_in   = 1'b1;
            reply_code = asc_pkg::REPLY_ARMED;
         end
         asc_pkg::OP_DISARM: begin
            armed_in   = 1'b0;
            reply_code = asc_pkg::REPLY_DISARMED;
         end
         asc_pkg::OP_STATUS: reply_code = asc_pkg::REPLY_STATUS;
         default: reply_code = asc_pkg::REPLY_NONE;
      endcase
   end

   // shared one-degree ramp step; a ramp already on target still waits one period
   always_comb begin
      angle_in  = angle_ff;
      ramp_done = 1'b0;
      if (tick_inc < step_min) begin
         tick_in = tick_inc;
      end else begin
         tick_in = '0;
         if (angle_ff == ramp_target) begin
            ramp_done = 1'b1;
         end else if (angle_ff < ramp_target) begin
            angle_in = angle_ff + 8'd1;
         end else begin
            angle_in = angle_ff - 8'd1;
         end
      end

      phase_in   = phase_ff;
      event_code = asc_pkg::EVENT_NONE;
      case (phase_ff)
         asc_pkg::PH_PREP: begin
            if (ramp_done) phase_in = asc_pkg::PH_DOWN;
         end
         asc_pkg::PH_DOWN: begin
            if (ramp_done) begin
               phase_in   = asc_pkg::PH_HOLD;
               event_code = asc_pkg::EVENT_DOWN;
            end
         end
         asc_pkg::PH_HOLD: begin
            angle_in = angle_ff;
            if (tick_inc >= hold_min) begin
               phase_in = asc_pkg::PH_UP;
               tick_in  = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         asc_pkg::PH_UP: begin
            if (ramp_done) begin
               phase_in   = asc_pkg::PH_LOCK;
               event_code = asc_pkg::EVENT_DONE;
            end
         end
         asc_pkg::PH_LOCK: begin
            angle_in = angle_ff;
            if (tick_inc >= lock_min) begin
               phase_in = asc_pkg::PH_IDLE;
               tick_in  = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         default: begin
            // idle: start on a falling button edge while armed
            angle_in = angle_ff;
            tick_in  = tick_ff;
            if (armed_in && prev_button_ff && !button_level) begin
               phase_in   = (angle_ff == up) ? asc_pkg::PH_DOWN : asc_pkg::PH_PREP;
               tick_in    = '0;
               event_code = asc_pkg::EVENT_STARTED;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         phase_ff       <= asc_pkg::PH_IDLE;
         angle_ff       <= asc_pkg::RESET_UP_POSITION;
         tick_ff        <= '0;
         prev_button_ff <= 1'b1;
      end else if (step) begin
         armed_ff       <= armed_in;
         phase_ff       <= phase_in;
         angle_ff       <= angle_in;
         tick_ff        <= tick_in;
         prev_button_ff <= button_level;
      end
   end

   always_comb begin
      result.servo_angle = angle_in;
      result.cut_busy    = phase_in inside {asc_pkg::PH_PREP, asc_pkg::PH_DOWN,
                                            asc_pkg::PH_HOLD, asc_pkg::PH_UP};
      result.is_armed    = armed_in;
      result.cut_event   = event_code;
      result.reply       = reply_code;
   end

endmodule

// File: hdl/asc_out_buf.sv
module asc_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  asc_pkg::rsp_type push_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_stall,
   output asc_pkg::rsp_type out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   asc_pkg::rsp_type main_ff, main_in;
   asc_pkg::rsp_type skid_ff, skid_in;
   logic             pop;

   assign pop = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_in = push_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            // hold the new item aside while the output is stalled
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

// File: hdl/armed_servo_cut_sequencer.sv
// Channel   Handshake            Payload
// req       req_valid/req_stall  req_operation, req_button_level
// rsp       rsp_valid/rsp_stall  rsp_servo_angle, rsp_cut_busy, rsp_is_armed,
//                                rsp_cut_event, rsp_reply
// csr       csr_write            csr_index, csr_data
//
// One item per cycle while req_stall is low; each result is registered in the
// output buffer. The sequencer state updates in the cycle of acceptance, set
// by one pass of the phase and ramp logic in asc_core.
// Reset is synchronous and restores the register defaults and the idle phase.
// A two-entry output buffer holds one extra item while rsp_stall is high;
// req_stall rises only once both entries hold items.
module armed_servo_cut_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_operation,
   input  logic                                req_button_level,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [asc_pkg::ANGLE_WIDTH-1:0]     rsp_servo_angle,
   output logic                                rsp_cut_busy,
   output logic                                rsp_is_armed,
   output logic [1:0]                          rsp_cut_event,
   output logic [1:0]                          rsp_reply,
   input  logic                                csr_write,
   input  logic [asc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [asc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   asc_pkg::cfg_type cfg;
   asc_pkg::rsp_type core_result;
   asc_pkg::rsp_type out_data;
   logic             buf_full;
   logic             accept;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   asc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .write (csr_write),
      .index (csr_index),
      .data  (csr_data),
      .cfg   (cfg)
   );

   asc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .operation    (req_operation),
      .button_level (req_button_level),
      .cfg          (cfg),
      .result       (core_result)
   );

   asc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_servo_angle = out_data.servo_angle;
   assign rsp_cut_busy    = out_data.cut_busy;
   assign rsp_is_armed    = out_data.is_armed;
   assign rsp_cut_event   = out_data.cut_event;
   assign rsp_reply       = out_data.reply;

endmodule
